/* rtl/core/musdur_pkg.sv */
package musdur_pkg;

  localparam int unsigned TICK_WIDTH_DEF = 32;
  localparam int unsigned POS_W          = 16;
  localparam int unsigned IN_DATA_W      = 8;

  // first byte of the score when the header gives a smaller offset
  localparam logic [POS_W-1:0] MIN_SCORE_START = 16'd8;
  localparam logic [POS_W-1:0] POS_START_LO    = 16'd6;
  localparam logic [POS_W-1:0] POS_START_HI    = 16'd7;

  localparam logic [2:0] EV_NOTE      = 3'd1;
  localparam logic [2:0] EV_SCORE_END = 3'd6;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_EVENT  = 3'd2,
    PH_NOTE   = 3'd3,
    PH_ARGS   = 3'd4,
    PH_DELAY  = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  // argument bytes that follow an event byte, by event type
  function automatic logic [1:0] arg_bytes(input logic [2:0] ev_type);
    logic [1:0] n;
    case (ev_type)
      3'd0:    n = 2'd1;
      3'd1:    n = 2'd1;
      3'd2:    n = 2'd1;
      3'd3:    n = 2'd1;
      3'd4:    n = 2'd2;
      3'd5:    n = 2'd0;
      3'd6:    n = 2'd0;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/mus_score_duration_counter_top.sv */
// channel | dir | handshake          | payload
// in_     | in  | tvalid/tready      | tdata[7:0] data_byte, tlast last_byte
// out_    | out | tvalid/tready      | tdata: tick_count, end_found above it
//
// one byte is taken per cycle while in_tready is high; each beat is parsed in the cycle it is accepted
// the result of a lump is registered at the clock edge that accepts its last byte
// in_tready drops only while a result is held and out_tready is low
// rst_n is synchronous; after reset and after every last byte the parser
// expects byte 0 of a new lump
module mus_score_duration_counter_top
  import musdur_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [IN_DATA_W-1:0]                 in_tdata,  // data_byte
  input  logic                                 in_tlast,  // last_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((TICK_WIDTH+1+7)/8)*8-1:0]    out_tdata  // tick_count, end_found
);

  localparam int unsigned OUT_W = ((TICK_WIDTH + 1 + 7) / 8) * 8;

  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [POS_W-1:0]      start_r, start_nxt;
  phase_t                phase_r, phase_nxt;
  logic [1:0]            args_r, args_nxt;
  logic                  dfollow_r, dfollow_nxt;
  logic [TICK_WIDTH-1:0] accum_r, accum_nxt;
  logic [TICK_WIDTH-1:0] tick_r, tick_nxt;
  logic                  ended_r, ended_nxt;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  logic                  in_beat;
  logic [2:0]            ev_type;
  logic [POS_W:0]        pos_inc;
  logic [POS_W-1:0]      start_hdr;
  logic [TICK_WIDTH-1:0] accum_shift;
  logic [TICK_WIDTH:0]   tick_sum;
  logic [TICK_WIDTH-1:0] tick_sat;
  logic [1:0]            args_dec;

  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign ev_type   = in_tdata[6:4];
  assign pos_inc   = {1'b0, pos_r} + 1'b1;
  assign start_hdr = {in_tdata, start_r[7:0]};

  // shifting in seven bits overflows once any of the top seven bits is set
  assign accum_shift = (accum_r[TICK_WIDTH-1 -: 7] != 7'd0) ? '1 :
                       {accum_r[TICK_WIDTH-8:0], in_tdata[6:0]};

  // one adder serves both the delay close and the lump close
  assign tick_sum = {1'b0, tick_r} + {1'b0, accum_shift};
  assign tick_sat = tick_sum[TICK_WIDTH] ? '1 : tick_sum[TICK_WIDTH-1:0];

  always_comb begin
    pos_nxt     = (pos_r == '1) ? pos_r : pos_inc[POS_W-1:0];
    start_nxt   = start_r;
    phase_nxt   = phase_r;
    args_nxt    = args_r;
    dfollow_nxt = dfollow_r;
    accum_nxt   = accum_r;
    tick_nxt    = tick_r;
    ended_nxt   = ended_r;
    args_dec    = (args_r != 2'd0) ? args_r - 2'd1 : args_r;
    case (phase_r)
      PH_HEADER: begin
        if (pos_r == POS_START_LO) begin
          start_nxt = {8'd0, in_tdata};
        end else if (pos_r == POS_START_HI) begin
          start_nxt = (start_hdr < MIN_SCORE_START) ? MIN_SCORE_START : start_hdr;
          phase_nxt = (start_nxt == MIN_SCORE_START) ? PH_EVENT : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (pos_inc >= {1'b0, start_r}) phase_nxt = PH_EVENT;
      end
      PH_EVENT: begin
        dfollow_nxt = in_tdata[7];
        if (ev_type == EV_SCORE_END) begin
          ended_nxt = 1'b1;
          phase_nxt = PH_DONE;
        end else if (ev_type == EV_NOTE) begin
          phase_nxt = PH_NOTE;
        end else if (arg_bytes(ev_type) != 2'd0) begin
          args_nxt  = arg_bytes(ev_type);
          phase_nxt = PH_ARGS;
        end else if (in_tdata[7]) begin
          accum_nxt = '0;
          phase_nxt = PH_DELAY;
        end else begin
          phase_nxt = PH_EVENT;
        end
      end
      PH_NOTE: begin
        if (in_tdata[7]) begin
          args_nxt  = 2'd1;
          phase_nxt = PH_ARGS;
        end else if (dfollow_r) begin
          accum_nxt = '0;
          phase_nxt = PH_DELAY;
        end else begin
          phase_nxt = PH_EVENT;
        end
      end
      PH_ARGS: begin
        args_nxt = args_dec;
        if (args_dec == 2'd0) begin
          if (dfollow_r) begin
            accum_nxt = '0;
            phase_nxt = PH_DELAY;
          end else begin
            phase_nxt = PH_EVENT;
          end
        end
      end
      PH_DELAY: begin
        if (in_tdata[7]) begin
          accum_nxt = accum_shift;
        end else begin
          tick_nxt  = tick_sat;
          accum_nxt = '0;
          phase_nxt = PH_EVENT;
        end
      end
      default: begin
      end
    endcase
  end

  // a lump that stops inside a delay still adds the part gathered so far
  always_comb begin
    out_data_nxt                 = '0;
    out_data_nxt[TICK_WIDTH-1:0] = (phase_r == PH_DELAY) ? tick_sat : tick_r;
    out_data_nxt[TICK_WIDTH]     = ended_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      start_r     <= '0;
      phase_r     <= PH_HEADER;
      args_r      <= '0;
      dfollow_r   <= 1'b0;
      accum_r     <= '0;
      tick_r      <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && !out_tready) || (in_beat && in_tlast);
      if (in_beat) begin
        if (in_tlast) begin
          pos_r       <= '0;
          start_r     <= '0;
          phase_r     <= PH_HEADER;
          args_r      <= '0;
          dfollow_r   <= 1'b0;
          accum_r     <= '0;
          tick_r      <= '0;
          ended_r     <= 1'b0;
        end else begin
          pos_r     <= pos_nxt;
          start_r   <= start_nxt;
          phase_r   <= phase_nxt;
          args_r    <= args_nxt;
          dfollow_r <= dfollow_nxt;
          accum_r   <= accum_nxt;
          tick_r    <= tick_nxt;
          ended_r   <= ended_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && in_tlast) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_tlast |=> phase_r == PH_HEADER && pos_r == '0 && out_valid_r)
    else $error("last beat did not restart the parser");

  a_done_ended: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> ended_r)
    else $error("score done without end flag");

  a_args_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ARGS |-> args_r != 2'd0)
    else $error("argument phase with no bytes left");

  a_delay_flag: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DELAY |-> dfollow_r)
    else $error("delay phase without delay flag");

endmodule

/* tb/sv/musdur_tick_check.sv */
package musdur_tb_pkg;
  import musdur_pkg::*;

  // remaining event types of the score format
  localparam logic [2:0] EV_RELEASE     = 3'd0;
  localparam logic [2:0] EV_PITCH_BEND  = 3'd2;
  localparam logic [2:0] EV_SYSTEM      = 3'd3;
  localparam logic [2:0] EV_CONTROLLER  = 3'd4;
  localparam logic [2:0] EV_MEASURE_END = 3'd5;
  localparam logic [2:0] EV_UNUSED      = 3'd7;

  // argument bytes after the event byte, not counting a note's volume byte
  function automatic int unsigned event_args(input logic [2:0] ev);
    if (ev == EV_CONTROLLER) return 2;
    if (ev == EV_MEASURE_END || ev == EV_SCORE_END) return 0;
    return 1;
  endfunction
endpackage

module musdur_tick_check
  import musdur_pkg::*, musdur_tb_pkg::*;
#(
  parameter int unsigned TICK_W = TICK_WIDTH_DEF,
  parameter int unsigned OUT_W  = ((TICK_W+1+7)/8)*8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tlast,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OUT_W-1:0]     out_tdata,
  output int                   fail_count,
  output int                   pending,
  output int                   lumps_checked,
  output int                   ends_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TICK_W-1:0] TICK_SAT = '1;

  typedef struct packed {
    logic [TICK_W-1:0] ticks;
    logic              ended;
  } lump_total_t;

  lump_total_t       totals_q[$];
  phase_t            phase;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  start;
  logic [1:0]        args_left;
  logic              delay_on;
  logic              ended;
  logic [TICK_W-1:0] delay_acc;
  logic [TICK_W-1:0] ticks;
  int                fails = 0;
  int                lumps = 0;
  int                ends  = 0;

  function automatic logic [TICK_W-1:0] sat_add(input logic [TICK_W-1:0] a,
                                                input logic [TICK_W-1:0] b);
    logic [TICK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TICK_W] ? TICK_SAT : s[TICK_W-1:0];
  endfunction

  task automatic clear_parser();
    phase     = PH_HEADER;
    pos       = '0;
    start     = '0;
    args_left = '0;
    delay_on  = 1'b0;
    ended     = 1'b0;
    delay_acc = '0;
    ticks     = '0;
  endtask

  task automatic args_done();
    if (delay_on) begin
      delay_acc = '0;
      phase     = PH_DELAY;
    end else begin
      phase = PH_EVENT;
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    logic [2:0]        ev;
    logic [TICK_W+6:0] shifted;
    ev = b[6:4];
    case (phase)
      PH_HEADER: begin
        if (pos == POS_START_LO) begin
          start = {8'h00, b};
        end else if (pos == POS_START_HI) begin
          start = {b, start[7:0]};
          if (start < MIN_SCORE_START) start = MIN_SCORE_START;
          phase = (start == MIN_SCORE_START) ? PH_EVENT : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if ({1'b0, pos} + 17'd1 >= {1'b0, start}) phase = PH_EVENT;
      end
      PH_EVENT: begin
        delay_on = b[7];
        if (ev == EV_SCORE_END) begin
          ended = 1'b1;
          phase = PH_DONE;
        end else if (ev == EV_NOTE) begin
          phase = PH_NOTE;
        end else if (event_args(ev) != 0) begin
          args_left = 2'(event_args(ev));
          phase     = PH_ARGS;
        end else begin
          args_done();
        end
      end
      PH_NOTE: begin
        // volume byte follows when the note byte has its top bit set
        if (b[7]) begin
          args_left = 2'd1;
          phase     = PH_ARGS;
        end else begin
          args_done();
        end
      end
      PH_ARGS: begin
        if (args_left != 0) args_left = args_left - 2'd1;
        if (args_left == 0) args_done();
      end
      PH_DELAY: begin
        shifted   = {delay_acc, b[6:0]};
        delay_acc = (shifted[TICK_W+6:TICK_W] != 0) ? TICK_SAT : shifted[TICK_W-1:0];
        if (!b[7]) begin
          ticks     = sat_add(ticks, delay_acc);
          delay_acc = '0;
          phase     = PH_EVENT;
        end
      end
      default: ;
    endcase

    if (pos != '1) pos = pos + 1'b1;

    if (last) begin
      // a delay cut short by the end of the lump still counts
      if (phase == PH_DELAY) ticks = sat_add(ticks, delay_acc);
      totals_q.push_back('{ticks: ticks, ended: ended});
      if (ended) ends++;
      clear_parser();
    end
  endtask

  always @(posedge clk) begin
    lump_total_t want;
    if (!rst_n) begin
      clear_parser();
      totals_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (totals_q.size() == 0) begin
          fails++;
          $display("%0t: result beat %h with no lump pending", $time, out_tdata);
        end else begin
          want = totals_q.pop_front();
          lumps++;
          if (out_tdata[TICK_W-1:0] !== want.ticks) begin
            fails++;
            $display("%0t: tick_count expected %0d, got %0d", $time, want.ticks,
                     out_tdata[TICK_W-1:0]);
          end
          if (out_tdata[TICK_W] !== want.ended) begin
            fails++;
            $display("%0t: end_found expected %0b, got %0b", $time, want.ended,
                     out_tdata[TICK_W]);
          end
          if ((out_tdata >> (TICK_W + 1)) !== '0) begin
            fails++;
            $display("%0t: padding expected 0, got %h", $time, out_tdata >> (TICK_W + 1));
          end
        end
      end
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
    end
    pending       <= totals_q.size();
    fail_count    <= fails;
    lumps_checked <= lumps;
    ends_seen     <= ends;
  end

endmodule

/* tb/sv/tb_mus_score_duration_counter_top.sv */
module tb_mus_score_duration_counter_top
  import musdur_pkg::*, musdur_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OUT_W = ((TICK_WIDTH_DEF+1+7)/8)*8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_BYTES   = 900;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;

  int         fail_count;
  int         pending;
  int         lumps_checked;
  int         ends_seen;
  int         bytes_sent    = 0;
  int         hold_requests = 0;
  bit         tx_quiet      = 1'b0;
  bit         tx_idle       = 1'b0;
  int         tx_stretch    = 0;
  logic [7:0] lump_q[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  mus_score_duration_counter_top #(.TICK_WIDTH(TICK_WIDTH_DEF)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  musdur_tick_check #(.TICK_W(TICK_WIDTH_DEF)) tick_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .lumps_checked(lumps_checked),
    .ends_seen    (ends_seen)
  );

  task automatic push_random(input int n);
    repeat (n) lump_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_header(input logic [15:0] offset);
    push_random(6);
    lump_q.push_back(offset[7:0]);
    lump_q.push_back(offset[15:8]);
    for (int k = 8; k < offset; k++) lump_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // big-endian 7-bit groups, top bit set on all but the final group
  task automatic add_delay();
    int groups;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: groups = 1;
      6, 7:             groups = 2;
      8:                groups = 3;
      default:          groups = $urandom_range(4, 6);
    endcase
    for (int g = 0; g < groups; g++)
      lump_q.push_back({g != groups - 1, 7'($urandom_range(0, 127))});
  endtask

  task automatic add_event(input logic [2:0] ev, input bit with_delay);
    logic [7:0] a;
    lump_q.push_back({with_delay, ev, 4'($urandom_range(0, 15))});
    if (ev == EV_NOTE) begin
      a = 8'($urandom_range(0, 255));
      lump_q.push_back(a);
      if (a[7]) push_random(1);
    end else begin
      push_random(event_args(ev));
    end
    if (with_delay && ev != EV_SCORE_END) add_delay();
  endtask

  task automatic send_lump();
    int gap;
    foreach (lump_q[i]) begin
      if (tx_stretch == 0) begin
        tx_stretch = $urandom_range(1, 24);
        tx_idle    = $urandom_range(0, 2) != 0;
      end
      tx_stretch--;
      gap = (tx_idle && !tx_quiet) ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= lump_q[i];
      in_tlast  <= (i == lump_q.size() - 1);
      do @(posedge clk); while (!in_tready);
      bytes_sent++;
    end
    lump_q.delete();
  endtask

  initial begin : rx_side
    int stall;
    int stretch;
    int holds_done;
    bit idling;
    stretch    = 0;
    holds_done = 0;
    idling     = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (stretch == 0) begin
        stretch = $urandom_range(1, 12);
        idling  = $urandom_range(0, 2) != 0;
      end
      stretch--;
      stall = idling ? $urandom_range(0, 14) : 0;
      if (holds_done < hold_requests) begin
        holds_done++;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int         random_bytes;
    int         pick;
    int         cut;
    logic [2:0] ev;
    logic [15:0] offset;
    random_bytes = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lump that stops inside the header
    lump_q.push_back(8'h4D);
    send_lump();

    // small offset, note with volume, saturating delay, then score end and a stray byte
    add_header(16'd3);
    lump_q.push_back({1'b1, EV_NOTE, 4'h2});
    lump_q.push_back(8'h85);
    lump_q.push_back(8'h7F);
    repeat (4) lump_q.push_back(8'hFF);
    lump_q.push_back(8'h7F);
    lump_q.push_back({1'b1, EV_MEASURE_END, 4'h0});
    lump_q.push_back(8'h01);
    lump_q.push_back({1'b1, EV_SCORE_END, 4'h0});
    lump_q.push_back(8'hAA);
    send_lump();

    // delay flagged but the lump stops on the argument byte
    add_header(16'd8);
    lump_q.push_back({1'b1, EV_RELEASE, 4'h3});
    lump_q.push_back(8'h12);
    send_lump();

    // long run of skipped bytes before the score starts
    tx_quiet = 1'b1;
    add_header(16'd150);
    add_event(EV_SYSTEM, 1'b1);
    add_event(EV_CONTROLLER, 1'b1);
    add_event(EV_UNUSED, 1'b1);
    add_event(EV_SCORE_END, 1'b0);
    send_lump();

    // long output hold while short lumps keep coming
    hold_requests++;
    repeat (6) begin
      push_random($urandom_range(1, 3));
      send_lump();
    end
    tx_quiet = 1'b0;

    while (random_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 19);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: offset = 16'd8;
        6, 7:             offset = 16'($urandom_range(0, 7));
        8:                offset = 16'($urandom_range(9, 40));
        default:          offset = 16'($urandom_range(41, 300));
      endcase
      add_header(offset);
      repeat ($urandom_range(0, 12)) begin
        ev = 3'($urandom_range(0, 7));
        if (ev == EV_SCORE_END) ev = EV_PITCH_BEND;
        add_event(ev, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 4) != 0) add_event(EV_SCORE_END, 1'($urandom_range(0, 1)));
      push_random($urandom_range(0, 4));
      if (pick < 3) begin
        cut = $urandom_range(1, lump_q.size());
        lump_q = lump_q[0:cut-1];
      end else if (pick < 5) begin
        lump_q.delete();
        push_random($urandom_range(1, 24));
      end
      random_bytes += lump_q.size();
      send_lump();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d bytes in %0d lumps, %0d of them reaching a score end,",
             bytes_sent, lumps_checked, ends_seen);
    $display("with a long skipped header and a %0d-cycle output hold", HOLD_CYCLES);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
